// File: rtl/fbc_pkg.sv
// Shared types, constants and the substitution function of the 64-bit Feistel block transform.
package fbc_pkg;

   localparam int KeyCount   = 8;
   localparam int RoundCount = 16;
   localparam int KeyIdxW    = 3;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
   } fbc_half_type;

   typedef struct packed {
      logic [31:0] k0;
      logic [31:0] k3;
   } fbc_mix_key_type;

   localparam logic [3:0] FBC_SBOX [0:7][0:15] = '{
      '{4'd4,  4'd10, 4'd9,  4'd2,  4'd13, 4'd8,  4'd0,  4'd14,
        4'd6,  4'd11, 4'd1,  4'd12, 4'd7,  4'd15, 4'd5,  4'd3},
      '{4'd14, 4'd11, 4'd4,  4'd12, 4'd6,  4'd13, 4'd15, 4'd10,
        4'd2,  4'd3,  4'd8,  4'd1,  4'd0,  4'd7,  4'd5,  4'd9},
      '{4'd5,  4'd8,  4'd1,  4'd13, 4'd10, 4'd3,  4'd4,  4'd2,
        4'd14, 4'd15, 4'd12, 4'd7,  4'd6,  4'd0,  4'd9,  4'd11},
      '{4'd7,  4'd13, 4'd10, 4'd1,  4'd0,  4'd8,  4'd9,  4'd15,
        4'd14, 4'd4,  4'd6,  4'd12, 4'd11, 4'd2,  4'd5,  4'd3},
      '{4'd6,  4'd12, 4'd7,  4'd1,  4'd5,  4'd15, 4'd13, 4'd8,
        4'd4,  4'd10, 4'd9,  4'd14, 4'd0,  4'd2,  4'd11, 4'd2},
      '{4'd4,  4'd11, 4'd10, 4'd0,  4'd7,  4'd2,  4'd1,  4'd13,
        4'd3,  4'd6,  4'd8,  4'd5,  4'd9,  4'd12, 4'd15, 4'd14},
      '{4'd13, 4'd11, 4'd4,  4'd1,  4'd3,  4'd15, 4'd5,  4'd9,
        4'd0,  4'd10, 4'd14, 4'd7,  4'd6,  4'd8,  4'd2,  4'd12},
      '{4'd1,  4'd15, 4'd13, 4'd0,  4'd5,  4'd7,  4'd10, 4'd4,
        4'd9,  4'd2,  4'd3,  4'd14, 4'd6,  4'd11, 4'd8,  4'd12}
   };

   localparam logic [KeyIdxW-1:0] FBC_KEY_ORDER [0:RoundCount-1] = '{
      3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
      3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0
   };

   function automatic logic [31:0] fbc_subst(input logic [31:0] value);
      logic [31:0] result;
      result = '0;
      for (int n = 0; n < 8; n++) begin
         result[28-4*n +: 4] = FBC_SBOX[n][value[28-4*n +: 4]];
      end
      return result;
   endfunction

endpackage

// File: rtl/feistel_block_cipher_64.sv
// Top level of the 64-bit Feistel block transform: key registers and sixteen half-rounds.
//
// A request on req_ carries one 64-bit block as two 32-bit halves; the matching
// response on rsp_ carries the swapped final halves. The same transform both
// encrypts and decrypts. The user must write key words through csr_ while no request is in
// flight; the block does not enforce it. Each write takes effect at the next rising clock edge.
//
// The datapath is sixteen half-rounds of two register stages each, 32 stages in
// all. One request is accepted in every cycle while the pipeline is not full.
// The round function's key add and its two 8 by 32 bit multiplies set the
// stage depth.
//
// Every stage holds its own valid bit. When the receiver stalls, the response
// holds and the stages behind it keep filling until the pipeline is full; only
// then does req_tready fall. Nothing is dropped or repeated.
//
// Reset clears all valid bits and sets every key word to zero.
module feistel_block_cipher_64
   import fbc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [63:0]        req_tdata,  // block_left [31:0], block_right [63:32]
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [63:0]        rsp_tdata,  // out_first [31:0], out_second [63:32]
   input  logic               csr_we,
   input  logic [KeyIdxW-1:0] csr_addr,
   input  logic [31:0]        csr_wdata
);

   logic [31:0]     key_ff [0:KeyCount-1];
   fbc_mix_key_type mix_key;

   logic            stage_valid [0:RoundCount];
   logic            stage_ready [0:RoundCount];
   fbc_half_type    stage_data  [0:RoundCount];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KeyCount; i++) begin
            key_ff[i] <= '0;
         end
      end else if (csr_we) begin
         key_ff[csr_addr] <= csr_wdata;
      end
   end

   assign mix_key.k0 = key_ff[0];
   assign mix_key.k3 = key_ff[3];

   assign stage_valid[0]  = req_tvalid;
   assign req_tready      = stage_ready[0];
   assign stage_data[0].x = req_tdata[31:0];
   assign stage_data[0].y = req_tdata[63:32];

   for (genvar r = 0; r < RoundCount; r++) begin : g_round
      fbc_round u_round (
         .clock     (clock),
         .reset     (reset),
         .round_key (key_ff[FBC_KEY_ORDER[r]]),
         .mix_key   (mix_key),
         .in_valid  (stage_valid[r]),
         .in_ready  (stage_ready[r]),
         .in_data   (stage_data[r]),
         .out_valid (stage_valid[r+1]),
         .out_ready (stage_ready[r+1]),
         .out_data  (stage_data[r+1])
      );
   end

   assign rsp_tvalid                = stage_valid[RoundCount];
   assign stage_ready[RoundCount]   = rsp_tready;
   assign rsp_tdata                 = {stage_data[RoundCount].x, stage_data[RoundCount].y};

endmodule

// File: rtl/fbc_round.sv
// One Feistel half-round as two pipeline stages: key add, then byte multiplies and substitution.
module fbc_round
   import fbc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic [31:0]     round_key,
   input  fbc_mix_key_type mix_key,
   input  logic            in_valid,
   output logic            in_ready,
   input  fbc_half_type    in_data,
   output logic            out_valid,
   input  logic            out_ready,
   output fbc_half_type    out_data
);

   logic         a_valid_ff;
   logic         a_valid_in;
   fbc_half_type a_half_ff;
   logic [31:0]  a_sum_ff;
   logic         a_en;

   logic         b_valid_ff;
   logic         b_valid_in;
   fbc_half_type b_half_ff;
   fbc_half_type b_half_in;
   logic         b_en;

   logic [31:0]  prod_hi;
   logic [31:0]  prod_lo;

   // The byte-wise mixing of the round function reduces to the xor of the two byte products.
   always_comb begin
      b_en       = !b_valid_ff || out_ready;
      a_en       = !a_valid_ff || b_en;
      a_valid_in = a_en ? in_valid : a_valid_ff;
      b_valid_in = b_en ? a_valid_ff : b_valid_ff;
      prod_hi    = {24'd0, a_sum_ff[31:24]} * mix_key.k0;
      prod_lo    = {24'd0, a_sum_ff[7:0]} * mix_key.k3;
      b_half_in.x = a_half_ff.y ^ fbc_subst(prod_hi ^ prod_lo);
      b_half_in.y = a_half_ff.x;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_en) begin
         a_half_ff <= in_data;
         a_sum_ff  <= in_data.x + round_key;
      end
      if (b_en) begin
         b_half_ff <= b_half_in;
      end
   end

   assign in_ready  = a_en;
   assign out_valid = b_valid_ff;
   assign out_data  = b_half_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !b_en |=> a_valid_ff && $stable(a_sum_ff) && $stable(a_half_ff))
      else $error("Stalled first stage lost or changed its request.");
   assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && !out_ready |=> b_valid_ff && $stable(b_half_ff))
      else $error("Stalled second stage lost or changed its request.");
   assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> a_valid_ff && b_valid_ff && !out_ready)
      else $error("Round refused a request while it had room.");
`endif

endmodule

// File: verif/tb_feistel_block_cipher_64.sv
// Self-checking testbench for the 64-bit Feistel block transform with random flow control.
`timescale 1ns / 100ps

module tb_feistel_block_cipher_64;
   import fbc_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_ITEMS  = 65;

   localparam logic [3:0] SUBST_TAB [0:7][0:15] = '{
      '{4'd4,  4'd10, 4'd9,  4'd2,  4'd13, 4'd8,  4'd0,  4'd14,
        4'd6,  4'd11, 4'd1,  4'd12, 4'd7,  4'd15, 4'd5,  4'd3},
      '{4'd14, 4'd11, 4'd4,  4'd12, 4'd6,  4'd13, 4'd15, 4'd10,
        4'd2,  4'd3,  4'd8,  4'd1,  4'd0,  4'd7,  4'd5,  4'd9},
      '{4'd5,  4'd8,  4'd1,  4'd13, 4'd10, 4'd3,  4'd4,  4'd2,
        4'd14, 4'd15, 4'd12, 4'd7,  4'd6,  4'd0,  4'd9,  4'd11},
      '{4'd7,  4'd13, 4'd10, 4'd1,  4'd0,  4'd8,  4'd9,  4'd15,
        4'd14, 4'd4,  4'd6,  4'd12, 4'd11, 4'd2,  4'd5,  4'd3},
      '{4'd6,  4'd12, 4'd7,  4'd1,  4'd5,  4'd15, 4'd13, 4'd8,
        4'd4,  4'd10, 4'd9,  4'd14, 4'd0,  4'd2,  4'd11, 4'd2},
      '{4'd4,  4'd11, 4'd10, 4'd0,  4'd7,  4'd2,  4'd1,  4'd13,
        4'd3,  4'd6,  4'd8,  4'd5,  4'd9,  4'd12, 4'd15, 4'd14},
      '{4'd13, 4'd11, 4'd4,  4'd1,  4'd3,  4'd15, 4'd5,  4'd9,
        4'd0,  4'd10, 4'd14, 4'd7,  4'd6,  4'd8,  4'd2,  4'd12},
      '{4'd1,  4'd15, 4'd13, 4'd0,  4'd5,  4'd7,  4'd10, 4'd4,
        4'd9,  4'd2,  4'd3,  4'd14, 4'd6,  4'd11, 4'd8,  4'd12}
   };

   typedef struct packed {
      logic [31:0] out_second;
      logic [31:0] out_first;
   } cipher_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [63:0]        req_tdata = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [63:0]        rsp_tdata;
   logic               csr_we = 1'b0;
   logic [KeyIdxW-1:0] csr_addr = '0;
   logic [31:0]        csr_wdata = '0;

   logic [31:0]       key_word [0:KeyCount-1];
   logic [63:0]       pending_blocks [$];
   cipher_result_type cipher_expected [$];
   logic              req_taken = 1'b0;
   logic              idle_on = 1'b1;
   int                gap_left = 0;
   int                stall_left = 0;
   int                cycle_count = 0;
   int                requests_sent = 0;
   int                responses_checked = 0;
   int                mismatch_count = 0;
   int                key_settings = 0;

   feistel_block_cipher_64 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   function automatic logic [31:0] subst_layer(input logic [31:0] v);
      logic [31:0] r;
      r = '0;
      for (int n = 0; n < 8; n++) begin
         r[28-4*n +: 4] = SUBST_TAB[n][v[28-4*n +: 4]];
      end
      return r;
   endfunction

   function automatic logic [31:0] round_mix(input logic [31:0] x);
      logic [31:0] s1, s2, s3, s4, s7, s9, s10, m;
      s1  = 32'(x[31:24]) * key_word[0];
      s2  = 32'(x[23:16]) + key_word[1];
      s3  = 32'(x[15:8]) + key_word[2];
      s4  = 32'(x[7:0]) * key_word[3];
      s7  = (s1 ^ s3) * key_word[4];
      s9  = ((s2 ^ s4) + s7) * key_word[5];
      s10 = s7 + s9;
      m   = (s1 ^ s9 ^ s2 ^ s10) ^ (s2 ^ s9 ^ s4 ^ s10);
      return subst_layer(m);
   endfunction

   function automatic cipher_result_type feistel_predict(input logic [63:0] blk);
      logic [31:0]       lh, rh;
      cipher_result_type res;
      lh = blk[31:0];
      rh = blk[63:32];
      for (int s = 0; s < RoundCount; s += 2) begin
         rh ^= round_mix(lh + key_word[(s < 8) ? s : 15 - s]);
         lh ^= round_mix(rh + key_word[(s + 1 < 8) ? s + 1 : 14 - s]);
      end
      res.out_first  = rh;
      res.out_second = lh;
      return res;
   endfunction

   function automatic int pick_pause();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 55) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 10);
      end else begin
         return $urandom_range(20, 60);
      end
   endfunction

   function automatic logic [31:0] random_half();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         return '0;
      end else if (r < 16) begin
         return '1;
      end else if (r < 24) begin
         return 32'($urandom_range(0, 255)) << (8 * $urandom_range(0, 3));
      end else begin
         return $urandom;
      end
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles.", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Request driver.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (gap_left > 0) begin
            req_tvalid <= 1'b0;
            gap_left   <= gap_left - 1;
         end else if (pending_blocks.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_blocks.pop_front();
            gap_left   <= pick_pause();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         stall_left <= pick_pause();
      end
   end

   // Monitor and checker.
   always @(posedge clock) begin
      cipher_result_type exp_res;
      cipher_result_type got_res;
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            cipher_expected.push_back(feistel_predict(req_tdata));
            requests_sent <= requests_sent + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got_res = rsp_tdata;
            if (cipher_expected.size() == 0) begin
               $error("Unexpected response: out_first %h out_second %h",
                      got_res.out_first, got_res.out_second);
               mismatch_count++;
            end else begin
               exp_res = cipher_expected.pop_front();
               responses_checked <= responses_checked + 1;
               if (got_res.out_first !== exp_res.out_first) begin
                  $error("out_first: expected %h, actual %h",
                         exp_res.out_first, got_res.out_first);
                  mismatch_count++;
               end
               if (got_res.out_second !== exp_res.out_second) begin
                  $error("out_second: expected %h, actual %h",
                         exp_res.out_second, got_res.out_second);
                  mismatch_count++;
               end
            end
         end
      end
   end

   task automatic write_key(input int idx, input logic [31:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= KeyIdxW'(idx);
      csr_wdata <= value;
      key_word[idx] = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      do begin
         @(posedge clock);
      end while (pending_blocks.size() != 0 || req_tvalid || cipher_expected.size() != 0);
   endtask

   task automatic random_phase(input int count);
      @(posedge clock);
      for (int i = 0; i < count; i++) begin
         pending_blocks.push_back({random_half(), random_half()});
      end
      wait_idle();
   endtask

   task automatic load_keys(input int setting);
      for (int k = 0; k < KeyCount; k++) begin
         case (setting)
            0: write_key(k, '1);
            1: write_key(k, 32'd1);
            2: write_key(k, {4{8'(8'h11 * (k + 1))}});
            default: write_key(k, $urandom);
         endcase
      end
      key_settings++;
   endtask

   initial begin
      logic [63:0]       seed_blk;
      cipher_result_type round_trip;
      for (int k = 0; k < KeyCount; k++) begin
         key_word[k] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      key_settings = 1;

      // Directed blocks under the all-zero reset keys.
      @(posedge clock);
      pending_blocks.push_back({32'h0000_0000, 32'h0000_0000});
      pending_blocks.push_back({32'hFFFF_FFFF, 32'hFFFF_FFFF});
      pending_blocks.push_back({32'h0000_0000, 32'hFFFF_FFFF});
      pending_blocks.push_back({32'hFFFF_FFFF, 32'h0000_0000});
      pending_blocks.push_back({32'h0000_0001, 32'h8000_0000});
      pending_blocks.push_back({32'h8000_0000, 32'h0000_0001});
      pending_blocks.push_back({32'h0000_00FF, 32'hFF00_0000});
      pending_blocks.push_back({32'h00FF_0000, 32'h0000_FF00});
      pending_blocks.push_back({32'h5555_5555, 32'hAAAA_AAAA});
      pending_blocks.push_back({32'hAAAA_AAAA, 32'h5555_5555});
      wait_idle();
      random_phase(PHASE_ITEMS);

      for (int setting = 0; setting < 6; setting++) begin
         idle_on = (setting != 3);
         load_keys(setting);
         if (setting == 0 || setting == 4) begin
            // Extreme halves and a block fed back from its own result.
            @(posedge clock);
            seed_blk   = {$urandom, $urandom};
            round_trip = feistel_predict(seed_blk);
            pending_blocks.push_back(seed_blk);
            pending_blocks.push_back({round_trip.out_second, round_trip.out_first});
            pending_blocks.push_back({round_trip.out_first, round_trip.out_second});
            pending_blocks.push_back({32'hFFFF_FFFF, 32'hFFFF_FFFF});
            pending_blocks.push_back({32'h0000_0000, 32'h0000_0000});
            wait_idle();
         end
         random_phase(PHASE_ITEMS);
      end

      idle_on = 1'b1;
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d responses for %0d requests across %0d key settings,",
               responses_checked, requests_sent, key_settings);
      $display("including zero, all-ones and unit keys with random flow control.");
      if (mismatch_count == 0 && cipher_expected.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
